### sv/coulomb_pair_energy_gradient_defines.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef COULOMB_PAIR_ENERGY_GRADIENT_DEFINES_SVH
`define COULOMB_PAIR_ENERGY_GRADIENT_DEFINES_SVH
`ifndef SYNTHESIS
`define CPEG_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("cpeg assertion failed");
`define CPEG_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("cpeg assertion failed");
`else
`define CPEG_ASSERT_IMPL(lbl, a, b)
`define CPEG_ASSERT_NEXT(lbl, a, b)
`endif
`endif

### sv/cpeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cpeg_pkg;
	localparam int MAX_ATOMS   = 4096;
	localparam int SQRT_STAGES = 25;
	localparam int DIV_STAGES  = 32;
	localparam int NLANE       = 4;

	localparam logic [1:0] REG_CUTOFF      = 2'd0;
	localparam logic [1:0] REG_SCALE       = 2'd1;
	localparam logic [1:0] REG_PAIR_FACTOR = 2'd2;

	localparam logic [1:0] KIND_NORMAL   = 2'd0;
	localparam logic [1:0] KIND_EXCLUDED = 2'd1;
	localparam logic [1:0] KIND_SCALED   = 2'd2;

	localparam logic [31:0] CUTOFF_RESET = 32'd6553600;
	localparam logic [31:0] SCALE_RESET  = 32'd21761484;
	localparam logic [17:0] FACTOR_RESET = 18'd65536;

	typedef struct packed {
		logic [11:0]        atom_i;
		logic [11:0]        atom_j;
		logic signed [31:0] pos_xi;
		logic signed [31:0] pos_yi;
		logic signed [31:0] pos_zi;
		logic signed [31:0] pos_xj;
		logic signed [31:0] pos_yj;
		logic signed [31:0] pos_zj;
		logic signed [15:0] charge_i;
		logic signed [15:0] charge_j;
		logic               pair_active;
		logic [1:0]         pair_kind;
	} pair_req_t;

	typedef struct packed {
		logic [11:0]        out_atom_i;
		logic [11:0]        out_atom_j;
		logic signed [31:0] pair_energy;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
		logic               counted;
		logic               coincident;
	} pair_res_t;

	typedef struct packed {
		logic [11:0] atom_i;
		logic [11:0] atom_j;
		logic        counted;
		logic        coinc;
		logic        qneg;
		logic [2:0]  dneg;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [63:0]       pm;
		logic [2:0][87:0]  ng;
		logic [51:0]       v;
		logic [51:0]       res;
	} sqrt_t;

	typedef struct packed {
		side_t                  side;
		logic [NLANE-1:0]       ovf;
		logic [NLANE-1:0][57:0] rem;
		logic [NLANE-1:0][31:0] nlo;
		logic [NLANE-1:0][31:0] q;
		logic [NLANE-1:0][57:0] den;
	} div_t;

	// saturate a quotient magnitude and apply the sign
	function automatic logic [31:0] sat_out(input logic ovf, input logic [31:0] q,
			input logic neg);
		logic [31:0] cap;
		logic [31:0] mag;
		cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		mag = (ovf || q > cap) ? cap : q;
		return neg ? 32'd0 - mag : mag;
	endfunction
endpackage
`default_nettype wire

### sv/cpeg_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface cpeg_pair_if;
	logic                valid;
	logic                ready;
	cpeg_pkg::pair_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cpeg_res_if;
	logic                valid;
	logic                ready;
	cpeg_pkg::pair_res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cpeg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### sv/coulomb_pair_energy_gradient.sv
`timescale 1ns / 1ps
`default_nettype none
`include "coulomb_pair_energy_gradient_defines.svh"
// channel     dir  handshake     payload
// pair_in     in   valid/ready   pair_req_t, one atom pair
// result_out  out  valid/ready   pair_res_t, one result per pair
// cfg         in   valid/ready   index 0..2, wdata (ready always high)
//
// One pair per cycle while no result is held in the skid; the path
// holds 66 registers: 5 front stages, 25 square-root bit stages, 2 setup,
// 32 divide bit stages, pack, output register.
// Whole pipeline advances on one enable; a two-entry output buffer (output
// register plus skid) lets one more pair in after a result stalls.
// arst_n clears valid bits and loads the register reset values.
module coulomb_pair_energy_gradient (
	input  wire        clk,
	input  wire        arst_n,
	cpeg_pair_if.sink  pair_in,
	cpeg_res_if.source result_out,
	cpeg_cfg_if.sink   cfg
);
	import cpeg_pkg::*;

	logic [31:0] cutoff_q, scale_q;
	logic [17:0] factor_q;
	logic        en;

	// config
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
			scale_q  <= SCALE_RESET;
			factor_q <= FACTOR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CUTOFF:      cutoff_q <= cfg.wdata;
				REG_SCALE:       scale_q  <= cfg.wdata;
				REG_PAIR_FACTOR: factor_q <= cfg.wdata[17:0];
				default: ;
			endcase
		end
	end

	assign pair_in.ready = en;

	// stage 1: differences, charge product, eligibility
	logic              v_s1, elig_s1, scaled_s1;
	logic [11:0]       ai_s1, aj_s1;
	logic [2:0][32:0]  d_s1;
	logic signed [31:0] qq_s1;
	logic [49:0]       kfm_s1;
	logic              elig_c;
	pair_req_t         rq;

	assign rq = pair_in.data;
	assign elig_c = rq.pair_active &&
		(rq.pair_kind == KIND_NORMAL || rq.pair_kind == KIND_SCALED) &&
		rq.charge_i != '0 && rq.charge_j != '0 &&
		32'(rq.atom_i) < MAX_ATOMS && 32'(rq.atom_j) < MAX_ATOMS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pair_in.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ai_s1     <= rq.atom_i;
			aj_s1     <= rq.atom_j;
			d_s1[0]   <= {rq.pos_xi[31], rq.pos_xi} - {rq.pos_xj[31], rq.pos_xj};
			d_s1[1]   <= {rq.pos_yi[31], rq.pos_yi} - {rq.pos_yj[31], rq.pos_yj};
			d_s1[2]   <= {rq.pos_zi[31], rq.pos_zi} - {rq.pos_zj[31], rq.pos_zj};
			qq_s1     <= 32'(rq.charge_i * rq.charge_j);
			elig_s1   <= elig_c;
			scaled_s1 <= rq.pair_kind == KIND_SCALED;
			kfm_s1    <= 50'(scale_q) * 50'(factor_q);
		end
	end

	// stage 2: magnitudes, far check, effective constant
	logic              v_s2, live_s2, qneg_s2;
	logic [11:0]       ai_s2, aj_s2;
	logic [2:0][23:0]  ad_s2;
	logic [2:0]        dneg_s2;
	logic [30:0]       qm_s2;
	logic [33:0]       kf_s2;
	logic [2:0][32:0]  adw;
	always_comb begin
		for (int c = 0; c < 3; c++)
			adw[c] = d_s1[c][32] ? 33'd0 - d_s1[c] : d_s1[c];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ai_s2   <= ai_s1;
			aj_s2   <= aj_s1;
			for (int c = 0; c < 3; c++) begin
				ad_s2[c]   <= adw[c][23:0];
				dneg_s2[c] <= d_s1[c][32];
			end
			live_s2 <= elig_s1 && adw[0][32:24] == '0 && adw[1][32:24] == '0 &&
				adw[2][32:24] == '0;
			qneg_s2 <= qq_s1[31];
			qm_s2   <= qq_s1[31] ? 31'(-qq_s1) : qq_s1[30:0];
			kf_s2   <= scaled_s1 ? kfm_s1[49:16] : {2'b00, scale_q};
		end
	end

	// stage 3: squares and charge-constant product
	logic              v_s3, live_s3, qneg_s3;
	logic [11:0]       ai_s3, aj_s3;
	logic [2:0][23:0]  ad_s3;
	logic [2:0]        dneg_s3;
	logic [2:0][47:0]  sq_s3;
	logic [63:0]       pm_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ai_s3   <= ai_s2;
			aj_s3   <= aj_s2;
			ad_s3   <= ad_s2;
			dneg_s3 <= dneg_s2;
			live_s3 <= live_s2;
			qneg_s3 <= qneg_s2;
			for (int c = 0; c < 3; c++)
				sq_s3[c] <= 48'(ad_s2[c]) * 48'(ad_s2[c]);
			pm_s3   <= 64'(65'(kf_s2) * 65'(qm_s2));
		end
	end

	// stage 4: squared distance, gradient numerator partial products
	logic              v_s4, live_s4, qneg_s4;
	logic [11:0]       ai_s4, aj_s4;
	logic [2:0]        dneg_s4;
	logic [49:0]       d2_s4;
	logic [63:0]       pm_s4;
	logic [2:0][55:0]  gl_s4, gh_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ai_s4   <= ai_s3;
			aj_s4   <= aj_s3;
			dneg_s4 <= dneg_s3;
			live_s4 <= live_s3;
			qneg_s4 <= qneg_s3;
			pm_s4   <= pm_s3;
			d2_s4   <= 50'(sq_s3[0]) + 50'(sq_s3[1]) + 50'(sq_s3[2]);
			for (int c = 0; c < 3; c++) begin
				gl_s4[c] <= 56'(pm_s3[31:0]) * 56'(ad_s3[c]);
				gh_s4[c] <= 56'(pm_s3[63:32]) * 56'(ad_s3[c]);
			end
		end
	end

	// stage 5: cutoff and coincidence, full numerators, root setup
	logic  v_s5;
	sqrt_t sq5_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq5_s5.side.atom_i  <= ai_s4;
			sq5_s5.side.atom_j  <= aj_s4;
			sq5_s5.side.qneg    <= qneg_s4;
			sq5_s5.side.dneg    <= dneg_s4;
			sq5_s5.side.counted <= live_s4 && d2_s4 != '0 &&
				d2_s4 < 50'({cutoff_q, 16'h0000});
			sq5_s5.side.coinc   <= live_s4 && d2_s4 == '0;
			sq5_s5.pm           <= pm_s4;
			for (int c = 0; c < 3; c++)
				sq5_s5.ng[c] <= (88'(gh_s4[c]) << 32) + 88'(gl_s4[c]);
			sq5_s5.v            <= 52'(d2_s4);
			sq5_s5.res          <= '0;
		end
	end

	// square root, one result bit per stage
	sqrt_t sq_s  [SQRT_STAGES];
	logic  sqv_s [SQRT_STAGES];
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		localparam logic [51:0] BITV = 52'(1) << (2 * (SQRT_STAGES - 1 - k));
		sqrt_t cur, nxt;
		logic  cv;
		if (k == 0) begin : g_first
			assign cur = sq5_s5;
			assign cv  = v_s5;
		end else begin : g_next
			assign cur = sq_s[k-1];
			assign cv  = sqv_s[k-1];
		end
		always_comb begin
			nxt = cur;
			if (cur.v >= cur.res + BITV) begin
				nxt.v   = cur.v - (cur.res + BITV);
				nxt.res = (cur.res >> 1) + BITV;
			end else begin
				nxt.res = cur.res >> 1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[k] <= 1'b0;
			else if (en) sqv_s[k] <= cv;
		end
		always_ff @(posedge clk) begin
			if (en) sq_s[k] <= nxt;
		end
	end

	// r squared
	logic             vr_s;
	side_t            sider_s;
	logic [63:0]      pmr_s;
	logic [2:0][87:0] ngr_s;
	logic [24:0]      rr_s;
	logic [49:0]      r2_s;
	sqrt_t            sql;
	assign sql = sq_s[SQRT_STAGES-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vr_s <= 1'b0;
		else if (en) vr_s <= sqv_s[SQRT_STAGES-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sider_s <= sql.side;
			pmr_s   <= sql.pm;
			ngr_s   <= sql.ng;
			rr_s    <= sql.res[24:0];
			r2_s    <= 50'(sql.res[24:0]) * 50'(sql.res[24:0]);
		end
	end

	// divider setup: overflow when quotient needs more than 32 bits
	div_t                  dv_s  [DIV_STAGES+1];
	logic                  dvv_s [DIV_STAGES+1];
	logic [NLANE-1:0][87:0] nn;
	logic [NLANE-1:0][57:0] dd;
	always_comb begin
		nn[0] = 88'(pmr_s);
		dd[0] = 58'({rr_s, 8'h00});
		for (int c = 0; c < 3; c++) begin
			nn[c+1] = ngr_s[c];
			dd[c+1] = {r2_s, 8'h00};
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dvv_s[0] <= 1'b0;
		else if (en) dvv_s[0] <= vr_s;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].side <= sider_s;
			for (int l = 0; l < NLANE; l++) begin
				dv_s[0].ovf[l] <= 58'(nn[l][87:32]) >= dd[l];
				dv_s[0].rem[l] <= (58'(nn[l][87:32]) >= dd[l]) ? '0 : 58'(nn[l][87:32]);
				dv_s[0].nlo[l] <= nn[l][31:0];
				dv_s[0].q[l]   <= '0;
				dv_s[0].den[l] <= dd[l];
			end
		end
	end

	// restoring divide, one quotient bit per stage in all four lanes
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		div_t nxt;
		always_comb begin
			logic [58:0] t;
			logic        qb;
			nxt = dv_s[k-1];
			for (int l = 0; l < NLANE; l++) begin
				t = {dv_s[k-1].rem[l], dv_s[k-1].nlo[l][31]};
				if (t >= {1'b0, dv_s[k-1].den[l]}) begin
					nxt.rem[l] = 58'(t - {1'b0, dv_s[k-1].den[l]});
					qb = 1'b1;
				end else begin
					nxt.rem[l] = t[57:0];
					qb = 1'b0;
				end
				nxt.nlo[l] = {dv_s[k-1].nlo[l][30:0], 1'b0};
				nxt.q[l]   = {dv_s[k-1].q[l][30:0], qb};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvv_s[k] <= 1'b0;
			else if (en) dvv_s[k] <= dvv_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) dv_s[k] <= nxt;
		end
	end

	// pack: saturate, sign, zero when not counted
	logic      fv_s;
	pair_res_t res_s;
	div_t      dl;
	pair_res_t pk;
	assign dl = dv_s[DIV_STAGES];
	always_comb begin
		pk.out_atom_i  = dl.side.atom_i;
		pk.out_atom_j  = dl.side.atom_j;
		pk.counted     = dl.side.counted;
		pk.coincident  = dl.side.coinc;
		pk.pair_energy = '0;
		pk.grad_x      = '0;
		pk.grad_y      = '0;
		pk.grad_z      = '0;
		if (dl.side.counted) begin
			pk.pair_energy = sat_out(dl.ovf[0], dl.q[0], dl.side.qneg);
			pk.grad_x = sat_out(dl.ovf[1], dl.q[1], dl.side.qneg == dl.side.dneg[0]);
			pk.grad_y = sat_out(dl.ovf[2], dl.q[2], dl.side.qneg == dl.side.dneg[1]);
			pk.grad_z = sat_out(dl.ovf[3], dl.q[3], dl.side.qneg == dl.side.dneg[2]);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fv_s <= 1'b0;
		else if (en) fv_s <= dvv_s[DIV_STAGES];
	end
	always_ff @(posedge clk) begin
		if (en) res_s <= pk;
	end

	// output register with skid
	logic      out_v_q, skid_v_q;
	pair_res_t out_q, skid_q;
	assign en = !skid_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result_out.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= fv_s;
			end
		end else if (fv_s && en) begin
			skid_v_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (!out_v_q || result_out.ready) begin
			out_q <= skid_v_q ? skid_q : res_s;
		end else if (fv_s && en) begin
			skid_q <= res_s;
		end
	end
	assign result_out.valid = out_v_q;
	assign result_out.data  = out_q;

	`CPEG_ASSERT_IMPL(a_skid_needs_out, skid_v_q, out_v_q)
	`CPEG_ASSERT_IMPL(a_flags_exclusive, out_v_q, !(out_q.counted && out_q.coincident))
	`CPEG_ASSERT_IMPL(a_zero_not_counted, out_v_q && !out_q.counted,
		out_q.pair_energy == '0 && out_q.grad_x == '0 && out_q.grad_y == '0 &&
		out_q.grad_z == '0)
	`CPEG_ASSERT_NEXT(a_stall_holds_last, fv_s && skid_v_q, fv_s)
endmodule
`default_nettype wire
